// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared codes, types and constants of the constant-folding ALU.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int unsigned HALF_WIDTH_DEF = 32;
  localparam int unsigned VAL_W          = 64;
  localparam int unsigned SPLIT_W        = 32;

  typedef enum logic [4:0] {
    FN_COND   = 5'd0,  FN_COMMA = 5'd1,  FN_LOR   = 5'd2,  FN_LAND  = 5'd3,
    FN_EQ     = 5'd4,  FN_NE    = 5'd5,  FN_LE    = 5'd6,  FN_LT    = 5'd7,
    FN_GE     = 5'd8,  FN_GT    = 5'd9,  FN_BOR   = 5'd10, FN_BAND  = 5'd11,
    FN_BXOR   = 5'd12, FN_LSH   = 5'd13, FN_RSH   = 5'd14, FN_ADD   = 5'd15,
    FN_SUB    = 5'd16, FN_MUL   = 5'd17, FN_DIV   = 5'd18, FN_MOD   = 5'd19,
    FN_NOT    = 5'd20, FN_BNOT  = 5'd21, FN_NEG   = 5'd22, FN_SIZEOF = 5'd23
  } func_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_ILLEGAL = 2'd1,
    FAULT_DIV0    = 2'd2,
    FAULT_MOD0    = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    SRC_SIMPLE = 3'd0,
    SRC_MUL    = 3'd1,
    SRC_QUOT   = 3'd2,
    SRC_REM    = 3'd3,
    SRC_SHL    = 3'd4,
    SRC_SHR    = 3'd5
  } src_e;

  // Everything one request carries alongside the divider.
  typedef struct packed {
    src_e                 src;
    logic                 kind;
    fault_e               fault;
    logic [VAL_W-1:0]     simple;
    logic [VAL_W-1:0]     lval;
    logic [VAL_W-1:0]     p0;
    logic [SPLIT_W-1:0]   p1;
    logic [SPLIT_W-1:0]   p2;
    logic                 wide_shift;
    logic                 q_neg;
    logic                 r_neg;
  } bundle_t;

endpackage

// File: hdl/constant_fold_alu_number_address_unit.sv
// ----------------------------------------------------------------------------
// constant_fold_alu_number_address_unit
// Tagged number/address ALU with a pipelined divider and shifter back end.
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------------
//   in       | in_valid_i/in_ready_o | func, cond/left/right kind and value
//   out      | out_valid_o/out_ready_i | result_kind, result_value, fault
//
// One request enters per cycle while the pipeline advances; its result passes
// through an input register, a decode register, one divider stage per
// quotient bit (shift counts are also reduced modulo HALF_WIDTH there) and
// the output register. Reset empties all stages. The pipeline
// advances whenever the output register is empty or being taken; otherwise
// every stage holds.
module constant_fold_alu_number_address_unit #(
  parameter int unsigned HALF_WIDTH = cfa_pkg::HALF_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [4:0]                func_i,
  input  logic                      cond_kind_i,
  input  logic [cfa_pkg::VAL_W-1:0] cond_value_i,
  input  logic                      left_kind_i,
  input  logic [cfa_pkg::VAL_W-1:0] left_value_i,
  input  logic                      right_kind_i,
  input  logic [cfa_pkg::VAL_W-1:0] right_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [cfa_pkg::VAL_W-1:0] result_value_o,
  output logic [1:0]                fault_o
);

  localparam int unsigned VW = cfa_pkg::VAL_W;
  localparam int unsigned SW = cfa_pkg::SPLIT_W;
  localparam logic [VW:0] NM1 = (65'd1 << HALF_WIDTH) - 65'd1;
  localparam logic [VW:0] AM1 = (65'd1 << (2 * HALF_WIDTH)) - 65'd1;
  localparam logic [VW-1:0] NMASK = NM1[VW-1:0];
  localparam logic [VW-1:0] AMASK = AM1[VW-1:0];

  logic                  adv;
  logic                  valid_s  [0:HALF_WIDTH];
  cfa_pkg::bundle_t      bundle_s [0:HALF_WIDTH];
  logic [HALF_WIDTH-1:0] rem_s    [0:HALF_WIDTH];
  logic [HALF_WIDTH-1:0] dvd_s    [0:HALF_WIDTH];
  logic [HALF_WIDTH-1:0] dsr_s    [0:HALF_WIDTH];

  logic                  out_valid_q;
  logic                  kind_q;
  logic [VW-1:0]         value_q;
  logic [1:0]            fault_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  cfa_front #(.HALF_WIDTH(HALF_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (in_valid_i),
    .func_i        (func_i),
    .cond_kind_i   (cond_kind_i),
    .cond_value_i  (cond_value_i),
    .left_kind_i   (left_kind_i),
    .left_value_i  (left_value_i),
    .right_kind_i  (right_kind_i),
    .right_value_i (right_value_i),
    .valid_o       (valid_s[0]),
    .bundle_o      (bundle_s[0]),
    .dvd_o         (dvd_s[0]),
    .dsr_o         (dsr_s[0])
  );

  assign rem_s[0] = '0;

  for (genvar i = 0; i < HALF_WIDTH; i++) begin : g_div
    cfa_div_stage #(.HALF_WIDTH(HALF_WIDTH)) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .valid_i  (valid_s[i]),
      .bundle_i (bundle_s[i]),
      .rem_i    (rem_s[i]),
      .dvd_i    (dvd_s[i]),
      .dsr_i    (dsr_s[i]),
      .valid_o  (valid_s[i+1]),
      .bundle_o (bundle_s[i+1]),
      .rem_o    (rem_s[i+1]),
      .dvd_o    (dvd_s[i+1]),
      .dsr_o    (dsr_s[i+1])
    );
  end

  cfa_pkg::bundle_t        b;
  logic [VW-1:0]           quo, rem, nsx, raw, masked;
  logic [HALF_WIDTH-1:0]   cnt;
  logic                    zero_div;

  always_comb begin
    b   = bundle_s[HALF_WIDTH];
    quo = VW'(dvd_s[HALF_WIDTH]);
    rem = VW'(rem_s[HALF_WIDTH]);
    cnt = rem_s[HALF_WIDTH];
    // A zero divisor only reaches here on a faulted request.
    zero_div = dsr_s[HALF_WIDTH] == '0;
    nsx = {{(VW - HALF_WIDTH){b.lval[HALF_WIDTH-1]}}, b.lval[HALF_WIDTH-1:0]};
    case (b.src)
      cfa_pkg::SRC_MUL:  raw = b.p0 + {b.p1 + b.p2, {SW{1'b0}}};
      cfa_pkg::SRC_QUOT: raw = b.q_neg ? ('0 - quo) : quo;
      cfa_pkg::SRC_REM:  raw = b.r_neg ? ('0 - rem) : rem;
      cfa_pkg::SRC_SHL: begin
        if (b.kind && b.wide_shift) raw = (((b.lval & NMASK) << cnt) & NMASK) << HALF_WIDTH;
        else raw = b.lval << cnt;
      end
      cfa_pkg::SRC_SHR: begin
        if (!b.kind) raw = VW'($signed(nsx) >>> cnt);
        else if (b.wide_shift) raw = (b.lval >> HALF_WIDTH) >> cnt;
        else raw = b.lval >> cnt;
      end
      default: raw = b.simple;
    endcase
    masked = raw & (b.kind ? AMASK : NMASK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_s[HALF_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fault_q <= b.fault;
      if (b.fault != cfa_pkg::FAULT_NONE || zero_div && b.src == cfa_pkg::SRC_QUOT) begin
        kind_q  <= 1'b0;
        value_q <= '0;
      end else begin
        kind_q  <= b.kind;
        value_q <= masked;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign result_value_o = value_q;
  assign fault_o        = fault_q;

endmodule

// File: hdl/cfa_front.sv
// ----------------------------------------------------------------------------
// cfa_front
// Input register and operation decode: simple results, partial products
// and divider operands.
// ----------------------------------------------------------------------------
module cfa_front #(
  parameter int unsigned HALF_WIDTH = cfa_pkg::HALF_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [4:0]                  func_i,
  input  logic                        cond_kind_i,
  input  logic [cfa_pkg::VAL_W-1:0]   cond_value_i,
  input  logic                        left_kind_i,
  input  logic [cfa_pkg::VAL_W-1:0]   left_value_i,
  input  logic                        right_kind_i,
  input  logic [cfa_pkg::VAL_W-1:0]   right_value_i,
  output logic                        valid_o,
  output cfa_pkg::bundle_t            bundle_o,
  output logic [HALF_WIDTH-1:0]       dvd_o,
  output logic [HALF_WIDTH-1:0]       dsr_o
);

  localparam int unsigned VW = cfa_pkg::VAL_W;
  localparam int unsigned SW = cfa_pkg::SPLIT_W;
  localparam logic [VW:0] NM1 = (65'd1 << HALF_WIDTH) - 65'd1;
  localparam logic [VW:0] AM1 = (65'd1 << (2 * HALF_WIDTH)) - 65'd1;
  localparam logic [VW-1:0] NMASK = NM1[VW-1:0];
  localparam logic [VW-1:0] AMASK = AM1[VW-1:0];
  localparam logic [VW-1:0] SIGNB = 64'd1 << (HALF_WIDTH - 1);
  localparam logic [VW-1:0] HW_V  = 64'(HALF_WIDTH);
  localparam logic [VW-1:0] SIZE_N = 64'((HALF_WIDTH + 7) / 8);
  localparam logic [HALF_WIDTH-1:0] HW_D = HALF_WIDTH'(HALF_WIDTH);

  logic            v1_q;
  logic [4:0]      func_q;
  logic            lk_q, rk_q;
  logic [VW-1:0]   cv_q, lv_q, rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_q <= func_i;
      lk_q   <= left_kind_i;
      rk_q   <= right_kind_i;
      cv_q   <= cond_value_i & (cond_kind_i ? AMASK : NMASK);
      lv_q   <= left_value_i & (left_kind_i ? AMASK : NMASK);
      rv_q   <= right_value_i & (right_kind_i ? AMASK : NMASK);
    end
  end

  logic                  tc, tl, tr, eqv, ltv, gtv, cmp_bit;
  logic [HALF_WIDTH-1:0] ln, rn, labs, rabs;
  cfa_pkg::bundle_t      b_d;
  logic [HALF_WIDTH-1:0] dvd_d, dsr_d;

  always_comb begin
    tc  = cv_q != '0;
    tl  = lv_q != '0;
    tr  = rv_q != '0;
    eqv = lv_q == rv_q;
    // Flipping the sign bit lets an unsigned compare give the signed order.
    ltv = lk_q ? (lv_q < rv_q) : ((lv_q ^ SIGNB) < (rv_q ^ SIGNB));
    gtv = lk_q ? (lv_q > rv_q) : ((lv_q ^ SIGNB) > (rv_q ^ SIGNB));
    ln   = lv_q[HALF_WIDTH-1:0];
    rn   = rv_q[HALF_WIDTH-1:0];
    labs = ln[HALF_WIDTH-1] ? (~ln + 1'b1) : ln;
    rabs = rn[HALF_WIDTH-1] ? (~rn + 1'b1) : rn;

    case (func_q)
      cfa_pkg::FN_EQ: cmp_bit = eqv;
      cfa_pkg::FN_NE: cmp_bit = !eqv;
      cfa_pkg::FN_LE: cmp_bit = !gtv;
      cfa_pkg::FN_LT: cmp_bit = ltv;
      cfa_pkg::FN_GE: cmp_bit = !ltv;
      default:        cmp_bit = gtv;
    endcase

    b_d            = '0;
    b_d.src        = cfa_pkg::SRC_SIMPLE;
    b_d.fault      = cfa_pkg::FAULT_NONE;
    b_d.lval       = lv_q;
    b_d.p0         = lv_q[SW-1:0] * rv_q[SW-1:0];
    b_d.p1         = SW'(lv_q[SW-1:0] * rv_q[VW-1:SW]);
    b_d.p2         = SW'(lv_q[VW-1:SW] * rv_q[SW-1:0]);
    b_d.wide_shift = rv_q >= HW_V;
    dvd_d          = rn;
    dsr_d          = HW_D;

    unique case (func_q) inside
      cfa_pkg::FN_COND: begin
        b_d.kind   = tc ? lk_q : rk_q;
        b_d.simple = tc ? lv_q : rv_q;
      end
      cfa_pkg::FN_COMMA: begin
        b_d.kind   = rk_q;
        b_d.simple = rv_q;
      end
      cfa_pkg::FN_LOR:  b_d.simple = {63'd0, tl || tr};
      cfa_pkg::FN_LAND: b_d.simple = {63'd0, tl && tr};
      cfa_pkg::FN_EQ, cfa_pkg::FN_NE, cfa_pkg::FN_LE, cfa_pkg::FN_LT,
      cfa_pkg::FN_GE, cfa_pkg::FN_GT: begin
        if (lk_q != rk_q) b_d.fault = cfa_pkg::FAULT_ILLEGAL;
        else b_d.simple = {63'd0, cmp_bit};
      end
      cfa_pkg::FN_BOR, cfa_pkg::FN_BAND, cfa_pkg::FN_BXOR: begin
        if (lk_q != rk_q) begin
          b_d.fault = cfa_pkg::FAULT_ILLEGAL;
        end else begin
          b_d.kind   = lk_q;
          b_d.simple = (func_q == cfa_pkg::FN_BOR)  ? (lv_q | rv_q) :
                       (func_q == cfa_pkg::FN_BAND) ? (lv_q & rv_q) : (lv_q ^ rv_q);
        end
      end
      cfa_pkg::FN_LSH, cfa_pkg::FN_RSH: begin
        // The divider reduces the count modulo the half width.
        if (rk_q) begin
          b_d.fault = cfa_pkg::FAULT_ILLEGAL;
        end else begin
          b_d.kind = lk_q;
          b_d.src  = (func_q == cfa_pkg::FN_LSH) ? cfa_pkg::SRC_SHL : cfa_pkg::SRC_SHR;
        end
      end
      cfa_pkg::FN_ADD: begin
        b_d.kind   = lk_q | rk_q;
        b_d.simple = lv_q + rv_q;
      end
      cfa_pkg::FN_SUB: begin
        b_d.kind   = lk_q | rk_q;
        b_d.simple = lv_q - rv_q;
      end
      cfa_pkg::FN_MUL: begin
        b_d.kind = lk_q | rk_q;
        b_d.src  = cfa_pkg::SRC_MUL;
      end
      cfa_pkg::FN_DIV, cfa_pkg::FN_MOD: begin
        if (rk_q) begin
          b_d.fault = cfa_pkg::FAULT_ILLEGAL;
        end else if (!tr) begin
          b_d.fault = (func_q == cfa_pkg::FN_DIV) ? cfa_pkg::FAULT_DIV0 : cfa_pkg::FAULT_MOD0;
        end else if (lk_q) begin
          if (func_q == cfa_pkg::FN_DIV) begin
            b_d.fault = cfa_pkg::FAULT_ILLEGAL;
          end else begin
            b_d.kind = 1'b1;
            b_d.src  = cfa_pkg::SRC_REM;
            dvd_d    = ln;
            dsr_d    = rn;
          end
        end else begin
          b_d.src   = (func_q == cfa_pkg::FN_DIV) ? cfa_pkg::SRC_QUOT : cfa_pkg::SRC_REM;
          b_d.q_neg = ln[HALF_WIDTH-1] ^ rn[HALF_WIDTH-1];
          b_d.r_neg = ln[HALF_WIDTH-1];
          dvd_d     = labs;
          dsr_d     = rabs;
        end
      end
      cfa_pkg::FN_NOT: b_d.simple = {63'd0, !tr};
      cfa_pkg::FN_BNOT: begin
        b_d.kind   = rk_q;
        b_d.simple = ~rv_q;
      end
      cfa_pkg::FN_NEG: begin
        b_d.kind   = rk_q;
        b_d.simple = '0 - rv_q;
      end
      cfa_pkg::FN_SIZEOF: b_d.simple = rk_q ? (SIZE_N << 1) : SIZE_N;
      default: b_d.fault = cfa_pkg::FAULT_ILLEGAL;
    endcase
  end

  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bundle_o <= b_d;
      dvd_o    <= dvd_d;
      dsr_o    <= dsr_d;
    end
  end

  assign valid_o = v2_q;

endmodule

// File: hdl/cfa_div_stage.sv
// ----------------------------------------------------------------------------
// cfa_div_stage
// One restoring divider stage: produces one quotient bit per register.
// ----------------------------------------------------------------------------
module cfa_div_stage #(
  parameter int unsigned HALF_WIDTH = cfa_pkg::HALF_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  cfa_pkg::bundle_t      bundle_i,
  input  logic [HALF_WIDTH-1:0] rem_i,
  input  logic [HALF_WIDTH-1:0] dvd_i,
  input  logic [HALF_WIDTH-1:0] dsr_i,
  output logic                  valid_o,
  output cfa_pkg::bundle_t      bundle_o,
  output logic [HALF_WIDTH-1:0] rem_o,
  output logic [HALF_WIDTH-1:0] dvd_o,
  output logic [HALF_WIDTH-1:0] dsr_o
);

  logic [HALF_WIDTH:0]   trial, diff;
  logic                  fits;
  logic [HALF_WIDTH-1:0] rem_d, dvd_d;
  logic                  valid_q;

  always_comb begin
    trial = {rem_i, dvd_i[HALF_WIDTH-1]};
    diff  = trial - {1'b0, dsr_i};
    fits  = trial >= {1'b0, dsr_i};
    rem_d = fits ? diff[HALF_WIDTH-1:0] : trial[HALF_WIDTH-1:0];
    // The dividend shifts out at the top while quotient bits shift in.
    dvd_d = {dvd_i[HALF_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bundle_o <= bundle_i;
      rem_o    <= rem_d;
      dvd_o    <= dvd_d;
      dsr_o    <= dsr_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// File: hdl/cfa_checker.sv
// ----------------------------------------------------------------------------
// cfa_checker
// Port-level checks of the constant-folding ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic [63:0] result_value_o,
  input logic [1:0]  fault_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_value_o))
  `ASSERT_IMPLY(a_fault_clean, clk_i, rst_ni, out_valid_o && fault_o != cfa_pkg::FAULT_NONE, !result_kind_o && result_value_o == 64'd0)
  `ASSERT_IMPLY(a_number_narrow, clk_i, rst_ni, out_valid_o && !result_kind_o, result_value_o[63:32] == 32'd0)
  `ASSERT_IMPLY(a_stall_blocks, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)

endmodule

bind constant_fold_alu_number_address_unit cfa_checker u_cfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .result_value_o (result_value_o),
  .fault_o        (fault_o)
);
